// ----- rtl/core/dbrr_pkg.sv -----
`default_nettype none

package dbrr_pkg;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int COORD_W    = 11;
  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 12;
  localparam int CUBE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int TILE_W     = 24;

  // largest tile edge exponent that a register write may set
  localparam int TILE_EXP_LIMIT = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_LUMA    = 2'd0;
  localparam logic [OP_W-1:0] OP_CR      = 2'd1;
  localparam logic [OP_W-1:0] OP_CB      = 2'd2;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // register reset values
  localparam logic [CUBE_W-1:0] CUBE_BITS_RESET    = 3'd4;
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RESET  = 12'd320;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RESET = 12'd240;

  // generator
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam int          DIR_SHIFT = 24;

  // tile directions
  typedef enum logic [1:0] {
    DIR_KEEP          = 2'd0,
    DIR_QUARTER       = 2'd1,
    DIR_HALF          = 2'd2,
    DIR_THREE_QUARTER = 2'd3
  } dir_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic index;
    logic lookup;
    logic emit;
    logic build_start;
    logic build_step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic build_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/dbrr_ctrl.sv -----
`default_nettype none

module dbrr_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [dbrr_pkg::OP_W-1:0]      operation,
  input  wire dbrr_pkg::dp_status_t           status,
  output logic                                in_stall,
  output dbrr_pkg::ctrl_cmd_t                 cmd
);
  import dbrr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INDEX  = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_EMIT   = 5'b01000,
    S_BUILD  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // only an idle controller takes a word
  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (operation == OP_REBUILD) begin
            cmd.build_start = 1'b1;
            state_next      = S_BUILD;
          end else begin
            state_next = S_INDEX;
          end
        end
      end
      S_INDEX: begin
        cmd.index  = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BUILD: begin
        if (status.build_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.build_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dbrr_datapath.sv -----
`default_nettype none

module dbrr_datapath #(
  parameter int MAP_DEPTH = 16384
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire dbrr_pkg::ctrl_cmd_t                    cmd,
  output dbrr_pkg::dp_status_t                        status,
  input  wire logic                                   cfg_valid,
  input  wire logic [dbrr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dbrr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [dbrr_pkg::OP_W-1:0]              operation,
  input  wire logic [dbrr_pkg::COORD_W-1:0]           column,
  input  wire logic [dbrr_pkg::COORD_W-1:0]           row,
  input  wire logic signed [dbrr_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic [dbrr_pkg::OP_W-1:0]                   plane,
  output logic [dbrr_pkg::COORD_W-1:0]                dest_column,
  output logic [dbrr_pkg::COORD_W-1:0]                dest_row,
  output logic signed [dbrr_pkg::SAMPLE_W-1:0]        value
);
  import dbrr_pkg::*;

  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int FW = $clog2(MAP_DEPTH + 1);
  localparam logic [TILE_W-1:0] DEPTH_EXT = TILE_W'(MAP_DEPTH);

  // configuration registers
  logic [CUBE_W-1:0] cube_bits;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;

  // held item
  logic [OP_W-1:0]            op_q;
  logic [COORD_W-1:0]         col_q;
  logic [COORD_W-1:0]         row_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  // lookup pipeline
  logic [TILE_W-1:0] idx_q;
  logic              pass_q;
  logic              hit_q;
  logic [1:0]        mem_q;

  // map build
  logic [31:0]       rng_q;
  logic [31:0]       rng_next;
  logic [TILE_W-1:0] t_q;
  logic [TILE_W-1:0] tiles_q;
  logic [FW-1:0]     fill_q;
  logic              t_in_map;

  // direction store
  logic [1:0] mem [MAP_DEPTH];

  // geometry
  logic               chroma;
  logic [CUBE_W-1:0]  eb;
  logic               bypass;
  logic [DIM_W-1:0]   map_w;
  logic [DIM_W-1:0]   map_h;
  logic [DIM_W-1:0]   luma_aw;
  logic [DIM_W-1:0]   luma_ah;
  logic [DIM_W-1:0]   area_w;
  logic [DIM_W-1:0]   area_h;
  logic               in_area;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_y;
  logic [22:0]        row_base;
  logic [TILE_W-1:0]  idx_calc;

  // turn inside the tile
  logic [COORD_W-1:0] mask;
  logic [COORD_W-1:0] lx;
  logic [COORD_W-1:0] ly;
  logic [COORD_W-1:0] nx;
  logic [COORD_W-1:0] ny;
  dir_t               dir;

  // register writes, out of range tile edge is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cube_bits    <= CUBE_BITS_RESET;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CUBE_BITS: begin
          if (cfg_data[CUBE_W-1:0] <= CUBE_W'(TILE_EXP_LIMIT)) begin
            cube_bits <= cfg_data[CUBE_W-1:0];
          end
        end
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      col_q    <= column;
      row_q    <= row;
      sample_q <= sample;
    end
  end

  // plane geometry, chroma tiles have half the luma edge
  assign chroma   = (op_q != OP_LUMA);
  assign bypass   = chroma && (cube_bits == '0);
  assign eb       = chroma ? (cube_bits - CUBE_W'(1)) : cube_bits;
  assign map_w    = frame_width >> cube_bits;
  assign map_h    = frame_height >> cube_bits;
  assign luma_aw  = map_w << cube_bits;
  assign luma_ah  = map_h << cube_bits;
  assign area_w   = chroma ? (luma_aw >> 1) : luma_aw;
  assign area_h   = chroma ? (luma_ah >> 1) : luma_ah;
  assign in_area  = ({1'b0, col_q} < area_w) && ({1'b0, row_q} < area_h);
  assign tile_x   = col_q >> eb;
  assign tile_y   = row_q >> eb;
  assign row_base = 23'(tile_y) * 23'(map_w);
  assign idx_calc = {1'b0, row_base} + TILE_W'(tile_x);

  // tile index stage
  always_ff @(posedge clk) begin
    if (cmd.index) begin
      idx_q  <= idx_calc;
      pass_q <= bypass || !in_area;
    end
  end

  // map read stage, entries at or above the fill mark read as keep
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_q <= !pass_q && (idx_q < TILE_W'(fill_q));
      mem_q <= mem[idx_q[AW-1:0]];
    end
  end

  // local coordinate turn
  assign mask = COORD_W'((12'd1 << eb) - 12'd1);
  assign lx   = col_q & mask;
  assign ly   = row_q & mask;
  assign dir  = hit_q ? dir_t'(mem_q) : DIR_KEEP;

  always_comb begin
    unique case (dir)
      DIR_QUARTER: begin
        nx = ly;
        ny = mask ^ lx;
      end
      DIR_HALF: begin
        nx = mask ^ lx;
        ny = mask ^ ly;
      end
      DIR_THREE_QUARTER: begin
        nx = mask ^ ly;
        ny = lx;
      end
      default: begin
        nx = lx;
        ny = ly;
      end
    endcase
  end

  // status back to the controller
  assign status = '{out_free:   (!out_valid || !out_stall),
                    build_done: (t_q == tiles_q)};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      plane       <= op_q;
      dest_column <= (col_q & ~mask) | nx;
      dest_row    <= (row_q & ~mask) | ny;
      value       <= sample_q;
    end
  end

  // generator and map walk, one tile per cycle
  assign rng_next = rng_q * LCG_MUL + LCG_ADD;
  assign t_in_map = (t_q < DEPTH_EXT);

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_q   <= '0;
      t_q     <= '0;
      tiles_q <= '0;
      fill_q  <= '0;
    end else if (cmd.build_start) begin
      t_q     <= '0;
      tiles_q <= TILE_W'(map_w) * TILE_W'(map_h);
    end else if (cmd.build_step) begin
      rng_q <= rng_next;
      t_q   <= t_q + TILE_W'(1);
      if (t_in_map && (t_q >= TILE_W'(fill_q))) begin
        fill_q <= FW'(t_q + TILE_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_step && t_in_map) begin
      mem[t_q[AW-1:0]] <= rng_next[DIR_SHIFT+1:DIR_SHIFT];
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    TILE_W'(fill_q) <= DEPTH_EXT)
    else $error("fill mark beyond map depth");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted word not presented");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.build_step |-> (t_q < tiles_q))
    else $error("map walk past last tile");

  a_lookup_order: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> $past(cmd.index))
    else $error("map read without tile index");

endmodule

`default_nettype wire

// ----- rtl/core/dice_block_rotation_remap.sv -----
`default_nettype none
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------
// in      | input     | in_valid / in_stall | operation, column, row, sample
// out     | output    | out_valid/out_stall | plane, dest_column, dest_row, value
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After acceptance a pixel word passes the tile index multiply, the map read and the turn
// into the output register; a new word is taken only once the last one is emitted, and an output stall holds that off.
// A rebuild word steps the generator once per tile and holds off input until the walk is done.
// Only one word is in flight; a finished word may wait in the output register while
// the next one is taken. Reset clears control state and the map fill mark, so the
// map reads as identity at once; no clearing pass. cfg_ready is always high.

module dice_block_rotation_remap #(
  parameter int MAP_DEPTH = 16384
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [dbrr_pkg::OP_W-1:0]              operation,
  input  wire logic [dbrr_pkg::COORD_W-1:0]           column,
  input  wire logic [dbrr_pkg::COORD_W-1:0]           row,
  input  wire logic signed [dbrr_pkg::SAMPLE_W-1:0]   sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [dbrr_pkg::OP_W-1:0]                   plane,
  output logic [dbrr_pkg::COORD_W-1:0]                dest_column,
  output logic [dbrr_pkg::COORD_W-1:0]                dest_row,
  output logic signed [dbrr_pkg::SAMPLE_W-1:0]        value,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [dbrr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dbrr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dbrr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers are always writable
  assign cfg_ready = 1'b1;

  dbrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  dbrr_datapath #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .column      (column),
    .row         (row),
    .sample      (sample),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .plane       (plane),
    .dest_column (dest_column),
    .dest_row    (dest_row),
    .value       (value)
  );

endmodule

`default_nettype wire

// ----- tb/tb_dice_block_rotation_remap.sv -----
`default_nettype none

module tb_dice_block_rotation_remap;
  import dbrr_pkg::*;

  localparam int MAP_DEPTH = 16384;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 68;
  // index that no register answers to
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one pixel word on the output side
  typedef struct {
    logic [OP_W-1:0]            plane;
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row;
    logic signed [SAMPLE_W-1:0] value;
  } pixel_word_t;

  // tile map, generator and register copy; predicts and checks pixel words
  class tile_rotation_predictor;
    logic [CUBE_W-1:0] cube;
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  fh;
    logic [31:0]       rng;
    dir_t              dir_map [MAP_DEPTH];
    pixel_word_t       pending[$];
    int                build_cycles;
    int                errors;
    int                pixel_count;
    int                build_count;
    int                checked_count;

    function new();
      cube = CUBE_BITS_RESET;
      fw = FRAME_WIDTH_RESET;
      fh = FRAME_HEIGHT_RESET;
      rng = '0;
      foreach (dir_map[i]) dir_map[i] = DIR_KEEP;
      build_cycles = 0;
      errors = 0;
      pixel_count = 0;
      build_count = 0;
      checked_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_CUBE_BITS: begin
          // out-of-range tile size is ignored
          if (d[CUBE_W-1:0] <= TILE_EXP_LIMIT) cube = d[CUBE_W-1:0];
        end
        REG_FRAME_WIDTH: fw = d;
        REG_FRAME_HEIGHT: fh = d;
        default: ;
      endcase
    endfunction

    // walk the map in row-major order, one generator step per tile
    function void rebuild();
      longint unsigned tiles;
      longint unsigned mw;
      longint unsigned mh;
      mw = fw >> cube;
      mh = fh >> cube;
      tiles = mw * mh;
      for (longint unsigned t = 0; t < tiles; t++) begin
        rng = rng * LCG_MUL + LCG_ADD;
        if (t < MAP_DEPTH) dir_map[t] = dir_t'(rng[DIR_SHIFT+1:DIR_SHIFT]);
      end
      build_cycles = int'(tiles) + 2;
      build_count++;
    endfunction

    // turn one coordinate inside its tile
    function void turn(int unsigned col, int unsigned row, int unsigned eb,
                       int unsigned aw, int unsigned ah,
                       output logic [COORD_W-1:0] dc, output logic [COORD_W-1:0] dr);
      int unsigned tile_edge;
      int unsigned lx;
      int unsigned ly;
      int unsigned nx;
      int unsigned ny;
      longint unsigned mw;
      longint unsigned idx;
      tile_edge = 1 << eb;
      lx = col & (tile_edge - 1);
      ly = row & (tile_edge - 1);
      dc = col[COORD_W-1:0];
      dr = row[COORD_W-1:0];
      if (col >= aw || row >= ah) return;
      mw = fw >> cube;
      idx = longint'(row >> eb) * mw + longint'(col >> eb);
      if (idx >= MAP_DEPTH) return;
      case (dir_map[idx])
        DIR_QUARTER: begin
          nx = ly;
          ny = tile_edge - 1 - lx;
        end
        DIR_HALF: begin
          nx = tile_edge - 1 - lx;
          ny = tile_edge - 1 - ly;
        end
        DIR_THREE_QUARTER: begin
          nx = tile_edge - 1 - ly;
          ny = lx;
        end
        default: begin
          nx = lx;
          ny = ly;
        end
      endcase
      dc = COORD_W'(col - lx + nx);
      dr = COORD_W'(row - ly + ny);
    endfunction

    // note an accepted input word
    function void note_word(logic [OP_W-1:0] op, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, logic signed [SAMPLE_W-1:0] smp);
      pixel_word_t w;
      int unsigned aw;
      int unsigned ah;
      if (op == OP_REBUILD) begin
        rebuild();
        return;
      end
      aw = (int'(fw) >> cube) << cube;
      ah = (int'(fh) >> cube) << cube;
      w.plane = op;
      w.column = col;
      w.row = row;
      w.value = smp;
      if (op == OP_LUMA) begin
        turn(col, row, cube, aw, ah, w.column, w.row);
      end else if (cube != 0) begin
        // chroma tiles are half the luma edge
        turn(col, row, cube - 1, aw >> 1, ah >> 1, w.column, w.row);
      end
      pending.push_back(w);
      pixel_count++;
    endfunction

    // compare a result word with the oldest prediction
    function void check_word(logic [OP_W-1:0] pl, logic [COORD_W-1:0] dc,
                             logic [COORD_W-1:0] dr, logic signed [SAMPLE_W-1:0] v);
      pixel_word_t w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: plane %0d column %0d row %0d value %0d",
               pl, dc, dr, v);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked_count++;
      if (pl !== w.plane) begin
        $error("plane mismatch: expected %0d, actual %0d", w.plane, pl);
        errors++;
      end
      if (dc !== w.column) begin
        $error("dest_column mismatch: expected %0d, actual %0d", w.column, dc);
        errors++;
      end
      if (dr !== w.row) begin
        $error("dest_row mismatch: expected %0d, actual %0d", w.row, dr);
        errors++;
      end
      if (v !== w.value) begin
        $error("value mismatch: expected %0d, actual %0d", w.value, v);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [OP_W-1:0]             operation = OP_LUMA;
  logic [COORD_W-1:0]          column = '0;
  logic [COORD_W-1:0]          row = '0;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [OP_W-1:0]             plane;
  logic [COORD_W-1:0]          dest_column;
  logic [COORD_W-1:0]          dest_row;
  logic signed [SAMPLE_W-1:0]  value;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_CUBE_BITS;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  tile_rotation_predictor sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // frame settings of the random phases
  int ph_cube [NUM_PHASES] = '{4, 5, 0, 2, 3, 5, 0, 2};
  int ph_w    [NUM_PHASES] = '{320, 2048, 64, 97, 2, 4095, 256, 2048};
  int ph_h    [NUM_PHASES] = '{240, 2048, 48, 83, 2, 4095, 80, 16};

  dice_block_rotation_remap u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .column(column),
    .row(row),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plane(plane),
    .dest_column(dest_column),
    .dest_row(dest_row),
    .value(value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #15000000;
    $display("Verification failed");
    $finish;
  end

  // watch both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_word(operation, column, row, sample);
    if (!rst && out_valid && !out_stall) sb.check_word(plane, dest_column, dest_row, value);
  end

  // receiver: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one word, idling at random first
  task automatic send_word(logic [OP_W-1:0] op, logic [COORD_W-1:0] col,
                           logic [COORD_W-1:0] rw, logic signed [SAMPLE_W-1:0] smp);
    bit taken;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    column <= col;
    row <= rw;
    sample <= smp;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every result, then let any rebuild finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (sb.build_cycles + 8) @(posedge clk);
    sb.build_cycles = 0;
  endtask

  task automatic set_frame(int cb, int w, int h);
    settle();
    cfg_write(REG_CUBE_BITS, CFG_DATA_W'(cb));
    cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  // random words, mostly pixels inside or just past the frame
  task automatic send_random(int count);
    logic [OP_W-1:0] op;
    int unsigned plane_w;
    int unsigned plane_h;
    int unsigned lim_c;
    int unsigned lim_r;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 4) begin
        send_word(OP_REBUILD, COORD_W'($urandom), COORD_W'($urandom), SAMPLE_W'($urandom));
      end else begin
        op = OP_W'($urandom_range(0, 2));
        plane_w = (op == OP_LUMA) ? sb.fw : sb.fw >> 1;
        plane_h = (op == OP_LUMA) ? sb.fh : sb.fh >> 1;
        lim_c = plane_w + plane_w / 8 + 1;
        lim_r = plane_h + plane_h / 8 + 1;
        if (lim_c > 2047) lim_c = 2047;
        if (lim_r > 2047) lim_r = 2047;
        c = ($urandom_range(0, 99) < 85) ? COORD_W'($urandom_range(0, lim_c))
                                         : COORD_W'($urandom);
        r = ($urandom_range(0, 99) < 85) ? COORD_W'($urandom_range(0, lim_r))
                                         : COORD_W'($urandom);
        send_word(op, c, r, SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity map straight after reset
    send_word(OP_LUMA, 0, 0, -32768);
    send_word(OP_LUMA, 2047, 2047, 32767);
    send_word(OP_CR, 159, 119, 16'sh1234);
    send_word(OP_CB, 0, 0, 0);
    // rebuild at reset size, then corners and edges of the area
    send_word(OP_REBUILD, 2047, 2047, -1);
    send_word(OP_LUMA, 319, 239, 100);
    send_word(OP_LUMA, 5, 3, -5);
    send_word(OP_LUMA, 320, 17, 7);
    send_word(OP_LUMA, 17, 240, 8);
    send_word(OP_CR, 7, 2, 9);
    send_word(OP_CB, 159, 119, 10);
    send_word(OP_CB, 160, 0, 11);

    // single-pixel tiles on the largest frame: chroma passes, far tiles pass
    set_frame(0, 2048, 2048);
    send_word(OP_LUMA, 3, 0, 12);
    send_word(OP_LUMA, 2047, 2047, 13);
    send_word(OP_CR, 100, 50, 14);

    // ignored writes and an empty map
    settle();
    cfg_write(REG_CUBE_BITS, 7);
    cfg_write(REG_CUBE_BITS, 6);
    cfg_write(REG_UNUSED, 12'hfff);
    cfg_write(REG_FRAME_WIDTH, 0);
    send_word(OP_REBUILD, 0, 0, 0);
    send_word(OP_LUMA, 0, 0, 15);

    // more tiles than the map holds
    set_frame(0, 256, 80);
    send_word(OP_REBUILD, 0, 0, 0);
    send_word(OP_LUMA, 255, 79, 16);
    send_word(OP_LUMA, 0, 63, 17);
    send_word(OP_LUMA, 255, 63, 18);
    send_word(OP_LUMA, 0, 64, 19);

    // random phases over frame settings and idling patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_frame(ph_cube[p], ph_w[p], ph_h[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      send_word(OP_REBUILD, 0, 0, 0);
      send_random(PHASE_WORDS / 2);
      // long output hold while words keep coming
      if (p == 0) hold_seq++;
      // sender pause until the pipe is empty
      if (p == 1) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random(PHASE_WORDS - PHASE_WORDS / 2);
    end

    settle();
    $display("covered %0d pixel words and %0d map rebuilds, %0d results checked",
             sb.pixel_count, sb.build_count, sb.checked_count);
    $display("frame settings from empty maps to beyond the map depth, idle and stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
